>>> rtl/edb_pkg.sv
// ----------------------------------------------------------------------------
// edb_pkg: shared types and constants for the envelope distance bounds unit
// Sample, sum and root widths, the queued sum pair and the queue status.
// ----------------------------------------------------------------------------
`default_nettype none

package edb_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned MAG_W      = 16;  // |a - b| of two samples fits 16 bits
  localparam int unsigned SQ_W       = 32;
  localparam int unsigned SUM_W      = 44;
  localparam int unsigned ROOT_W     = 22;
  localparam int unsigned STEP_W     = 5;
  localparam int unsigned SHIFT_W    = 6;
  localparam logic [STEP_W-1:0] LAST_ROOT_STEP = STEP_W'(ROOT_W - 1);

  typedef struct packed {
    logic [SUM_W-1:0] upper;
    logic [SUM_W-1:0] lower;
  } sums_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

>>> rtl/edb_front.sv
// ----------------------------------------------------------------------------
// edb_front: sample intake and accumulation
// Three stages: distances, squares, saturating sums. Pushes sums on last step.
// ----------------------------------------------------------------------------
`default_nettype none

module edb_front import edb_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic signed [SAMPLE_W-1:0] query_value_i,
  input  wire logic signed [SAMPLE_W-1:0] env_low_i,
  input  wire logic signed [SAMPLE_W-1:0] env_high_i,
  input  wire logic                       last_step_i,
  input  wire logic                       pop_i,
  output logic                            push_o,
  output sums_t                           push_data_o
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  // credits: queue slots not yet claimed by a last word
  logic [CntW-1:0] credit_q, credit_d;
  logic            accept, take;

  assign in_ready_o = (credit_q != '0);
  assign accept     = in_valid_i & in_ready_o;
  assign take       = accept & last_step_i;

  always_comb begin
    credit_d = credit_q;
    unique case ({take, pop_i})
      2'b10:   credit_d = credit_q - CntW'(1);
      2'b01:   credit_d = credit_q + CntW'(1);
      default: credit_d = credit_q;
    endcase
  end

  // stage 1: magnitudes of both differences, outside flag
  logic signed [SAMPLE_W:0] diff_lo, diff_hi, neg_lo, neg_hi;
  logic [MAG_W-1:0]         mag_lo, mag_hi;
  logic                     outside;

  assign diff_lo = {query_value_i[SAMPLE_W-1], query_value_i}
                 - {env_low_i[SAMPLE_W-1], env_low_i};
  assign diff_hi = {query_value_i[SAMPLE_W-1], query_value_i}
                 - {env_high_i[SAMPLE_W-1], env_high_i};
  assign neg_lo  = '0 - diff_lo;
  assign neg_hi  = '0 - diff_hi;
  assign mag_lo  = diff_lo[SAMPLE_W] ? neg_lo[MAG_W-1:0] : diff_lo[MAG_W-1:0];
  assign mag_hi  = diff_hi[SAMPLE_W] ? neg_hi[MAG_W-1:0] : diff_hi[MAG_W-1:0];
  assign outside = (query_value_i < env_low_i) || (query_value_i > env_high_i);

  logic             s1_valid_q;
  logic [MAG_W-1:0] s1_mag_lo_q, s1_mag_hi_q;
  logic             s1_out_q, s1_last_q;

  // stage 2: squares of the nearer and farther edge
  logic [MAG_W-1:0] mag_min, mag_max;
  logic [SQ_W-1:0]  sq_min, sq_max;

  assign mag_min = (s1_mag_lo_q < s1_mag_hi_q) ? s1_mag_lo_q : s1_mag_hi_q;
  assign mag_max = (s1_mag_lo_q < s1_mag_hi_q) ? s1_mag_hi_q : s1_mag_lo_q;
  assign sq_min  = SQ_W'(mag_min) * SQ_W'(mag_min);
  assign sq_max  = SQ_W'(mag_max) * SQ_W'(mag_max);

  logic            s2_valid_q;
  logic [SQ_W-1:0] s2_min_q, s2_max_q;
  logic            s2_last_q;

  // stage 3: saturating sums
  logic [SUM_W-1:0] lower_sum_q, upper_sum_q;
  logic [SUM_W:0]   lower_wide, upper_wide;
  logic [SUM_W-1:0] lower_sat, upper_sat;

  assign lower_wide = {1'b0, lower_sum_q} + (SUM_W+1)'(s2_min_q);
  assign upper_wide = {1'b0, upper_sum_q} + (SUM_W+1)'(s2_max_q);
  assign lower_sat  = lower_wide[SUM_W] ? '1 : lower_wide[SUM_W-1:0];
  assign upper_sat  = upper_wide[SUM_W] ? '1 : upper_wide[SUM_W-1:0];

  assign push_o            = s2_valid_q & s2_last_q;
  assign push_data_o.lower = lower_sat;
  assign push_data_o.upper = upper_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q    <= CntW'(QueueDepth);
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      lower_sum_q <= '0;
      upper_sum_q <= '0;
    end else begin
      credit_q   <= credit_d;
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      if (s2_valid_q) begin
        if (s2_last_q) begin
          lower_sum_q <= '0;
          upper_sum_q <= '0;
        end else begin
          lower_sum_q <= lower_sat;
          upper_sum_q <= upper_sat;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mag_lo_q <= mag_lo;
      s1_mag_hi_q <= mag_hi;
      s1_out_q    <= outside;
      s1_last_q   <= last_step_i;
    end
    if (s1_valid_q) begin
      s2_min_q  <= s1_out_q ? sq_min : '0;
      s2_max_q  <= sq_max;
      s2_last_q <= s1_last_q;
    end
  end

endmodule

`default_nettype wire

>>> rtl/edb_queue.sv
// ----------------------------------------------------------------------------
// edb_queue: small queue of finished sum pairs
// Register array with wrap pointers; head is read at the read pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module edb_queue import edb_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire sums_t   push_data_i,
  input  wire logic    pop_i,
  output sums_t        head_o,
  output queue_status_t status_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  sums_t           entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign head_o         = entries_q[rd_ptr_q];
  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/edb_isqrt.sv
// ----------------------------------------------------------------------------
// edb_isqrt: iterative floor square root of a 44-bit sum
// One result bit per cycle; done pulses after the last step.
// ----------------------------------------------------------------------------
`default_nettype none

module edb_isqrt import edb_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SUM_W-1:0] operand_i,
  output logic [ROOT_W-1:0]     root_o,
  output logic                  done_o
);

  logic [SUM_W-1:0]   rem_q, rem_d;
  logic [SUM_W-1:0]   res_q, res_d;
  logic [STEP_W-1:0]  step_q;
  logic               running_q, done_q;
  logic [SHIFT_W-1:0] sh;
  logic [SUM_W-1:0]   bit_val, trial;

  // bit starts at 2^42 and moves down two places per step
  assign sh      = SHIFT_W'(SUM_W - 2) - {step_q, 1'b0};
  assign bit_val = {{(SUM_W-1){1'b0}}, 1'b1} << sh;
  assign trial   = res_q + bit_val;

  always_comb begin
    if (rem_q >= trial) begin
      rem_d = rem_q - trial;
      res_d = (res_q >> 1) + bit_val;
    end else begin
      rem_d = rem_q;
      res_d = res_q >> 1;
    end
  end

  assign root_o = res_q[ROOT_W-1:0];
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
      step_q    <= '0;
    end else begin
      done_q <= running_q && (step_q == LAST_ROOT_STEP) && !start_i;
      if (start_i) begin
        running_q <= 1'b1;
        step_q    <= '0;
      end else if (running_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == LAST_ROOT_STEP) begin
          running_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= operand_i;
      res_q <= '0;
    end else if (running_q) begin
      rem_q <= rem_d;
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/edb_back.sv
// ----------------------------------------------------------------------------
// edb_back: root stage and result register
// Pops one sum pair, runs both roots side by side, holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module edb_back import edb_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire sums_t         head_i,
  input  wire queue_status_t status_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [ROOT_W-1:0]  lower_bound_o,
  output logic [ROOT_W-1:0]  upper_bound_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_ROOT = 3'b010,
    S_HOLD = 3'b100
  } back_state_e;

  back_state_e        state_q, state_d;
  logic [ROOT_W-1:0]  lower_root, upper_root;
  logic [ROOT_W-1:0]  lower_q, upper_q;
  logic               lower_done, upper_done;

  assign pop_o = (state_q == S_IDLE) && !status_i.empty;

  edb_isqrt u_root_lower (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (pop_o),
    .operand_i (head_i.lower),
    .root_o    (lower_root),
    .done_o    (lower_done)
  );

  edb_isqrt u_root_upper (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (pop_o),
    .operand_i (head_i.upper),
    .root_o    (upper_root),
    .done_o    (upper_done)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (pop_o) state_d = S_ROOT;
      S_ROOT: if (lower_done && upper_done) state_d = S_HOLD;
      S_HOLD: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o   = (state_q == S_HOLD);
  assign lower_bound_o = lower_q;
  assign upper_bound_o = upper_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_ROOT) && lower_done && upper_done) begin
      lower_q <= lower_root;
      upper_q <= upper_root;
    end
  end

endmodule

`default_nettype wire

>>> rtl/envelope_distance_bounds_unit.sv
// ----------------------------------------------------------------------------
// envelope_distance_bounds_unit: lower/upper envelope distance bounds
// Input: one word per cycle while a queue credit remains.
// A last word passes the three-stage front, the queue and the 22-step root
// unit, then the result register.
// Root unit frees a queue slot each time it pops a sum pair; ready drops once QueueDepth wait.
// Reset (rst_ni low, async) clears both sums, queue, credits and root state.
// ----------------------------------------------------------------------------
`default_nettype none

module envelope_distance_bounds_unit import edb_pkg::*; #(
  parameter int unsigned QueueDepth = 2  // sum pairs buffered, 2 or more
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input words
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // [15:0] query_value, [31:16] env_low,
                                          // [47:32] env_high
  input  wire logic        s_axis_tlast,  // last_step
  // result words
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata   // [21:0] lower_bound, [43:22] upper_bound,
                                          // [47:44] zero
);

  // front -> queue
  logic          push;
  sums_t         push_data;
  // queue -> back
  sums_t         head;
  queue_status_t q_status;
  logic          pop;

  logic [ROOT_W-1:0] lower_bound, upper_bound;

  // Front: distances, squares, saturating sums; a word per cycle while credits last.
  // It holds one credit per queue slot so a last word never finds the queue full.
  edb_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .query_value_i (s_axis_tdata[15:0]),
    .env_low_i     (s_axis_tdata[31:16]),
    .env_high_i    (s_axis_tdata[47:32]),
    .last_step_i   (s_axis_tlast),
    .pop_i         (pop),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  // Queue of finished sum pairs, decouples the front from the root stage.
  edb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  // Back: both roots in parallel, then the result register.
  edb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .status_i      (q_status),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .lower_bound_o (lower_bound),
    .upper_bound_o (upper_bound)
  );

  assign m_axis_tdata = {4'b0000, upper_bound, lower_bound};

`ifndef SYNTHESIS
  // credits must keep the queue from overflowing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (!q_status.full || pop))
    else $error("push into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // lower sum never exceeds upper sum, so neither do their roots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[21:0] <= m_axis_tdata[43:22]))
    else $error("lower bound above upper bound");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (push_data.lower <= push_data.upper))
    else $error("lower sum above upper sum");
`endif

endmodule

`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking regression for envelope_distance_bounds_unit
// A table of directed steps, then random series, drives the input stream.
// Both stream sides idle at random. Each accepted word is run through a local
// bound predictor, and every result word is checked field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import edb_pkg::*;

  localparam int RANDOM_ITEMS   = 1600;
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no handshake on either side
  localparam int DRAIN_CYCLES   = 60;    // root unit latency plus margin
  localparam int LONG_HOLD      = 400;   // receiver hold-off that backs up the queue
  localparam int HOLD_AFTER     = 25;    // results seen before that hold-off

  // one input word, packed in tdata order (query lowest)
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] env_hi;
    logic signed [SAMPLE_W-1:0] env_lo;
    logic signed [SAMPLE_W-1:0] query;
    logic                       last;
  } step_word_t;

  typedef struct packed {
    logic [ROOT_W-1:0] upper;
    logic [ROOT_W-1:0] lower;
  } bounds_t;

  // directed row: a word sent reps times, last only on the final copy
  typedef struct {
    step_word_t  w;
    int unsigned reps;
    bit          typed;
    bounds_t     want;
  } dir_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  envelope_distance_bounds_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state: running sums of the open series
  logic [SUM_W-1:0] lower_acc = '0;
  logic [SUM_W-1:0] upper_acc = '0;
  bounds_t          pending_bounds[$];

  int fail_count      = 0;
  int words_sent      = 0;
  int series_sent     = 0;
  int results_seen    = 0;
  int saturated_count = 0;
  int edge_steps      = 0;
  int inverted_steps  = 0;
  int idle_cycles     = 0;
  bit tx_busy         = 1'b0;
  bit rx_busy         = 1'b0;

  // ---------------------------------------------------------------- predictor
  function automatic logic [SQ_W-1:0] sq_dist(input logic signed [SAMPLE_W-1:0] a,
                                               input logic signed [SAMPLE_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return SQ_W'(d * d);
  endfunction

  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] acc,
                                               input logic [SQ_W-1:0]  term);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W+1)'(term);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  // floor root, one result bit per pass from the top
  function automatic logic [ROOT_W-1:0] floor_root(input logic [SUM_W-1:0] x);
    logic [ROOT_W-1:0] r;
    logic [ROOT_W-1:0] cand;
    r = '0;
    for (int i = ROOT_W - 1; i >= 0; i--) begin
      cand = r | (ROOT_W'(1) << i);
      if ((longint'(cand) * longint'(cand)) <= longint'(x)) r = cand;
    end
    return r;
  endfunction

  task automatic accumulate_step(input step_word_t w, output bit done, output bounds_t b);
    logic [SQ_W-1:0] d_lo;
    logic [SQ_W-1:0] d_hi;
    d_lo = sq_dist(w.query, w.env_lo);
    d_hi = sq_dist(w.query, w.env_hi);
    if (w.env_lo > w.env_hi) inverted_steps++;
    if (w.query == w.env_lo || w.query == w.env_hi) edge_steps++;
    // edge counts as inside: only a strict miss feeds the lower sum
    if (w.query < w.env_lo || w.query > w.env_hi)
      lower_acc = sat_sum(lower_acc, (d_lo < d_hi) ? d_lo : d_hi);
    upper_acc = sat_sum(upper_acc, (d_lo < d_hi) ? d_hi : d_lo);
    done = w.last;
    b    = '0;
    if (w.last) begin
      b.lower = floor_root(lower_acc);
      b.upper = floor_root(upper_acc);
      if (upper_acc == {SUM_W{1'b1}}) saturated_count++;
      lower_acc = '0;
      upper_acc = '0;
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  function automatic int idle_gap(input bit busy);
    int r;
    if (busy) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int rnd16();
    return int'($signed(16'($urandom)));
  endfunction

  function automatic int extreme16();
    case ($urandom_range(4))
      0:       return -32768;
      1:       return 32767;
      2:       return -1;
      3:       return 0;
      default: return rnd16();
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clamp16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return SAMPLE_W'(v);
  endfunction

  function automatic step_word_t random_step(input bit last);
    step_word_t w;
    int mode, q, lo, hi, span;
    mode = $urandom_range(99);
    if (mode < 15) begin
      q = rnd16(); lo = rnd16(); hi = rnd16();
    end else if (mode < 70) begin
      // well-formed envelope, query around it; the upper part lands on an edge
      span = ($urandom_range(9) == 0) ? int'($urandom_range(65535))
                                      : int'($urandom_range(2000));
      lo = rnd16();
      hi = int'(clamp16(lo + span));
      q  = lo - 3000 + int'($urandom_range(hi - lo + 6000));
      if (mode >= 55) q = $urandom_range(1) ? lo : hi;
    end else if (mode < 80) begin
      // inverted envelope: low strictly above high
      hi = int'(clamp16(rnd16() - 1));
      lo = int'(clamp16(hi + 1 + int'($urandom_range(3000))));
      q  = hi - 500 + int'($urandom_range(lo - hi + 1000));
    end else if (mode < 90) begin
      q = extreme16(); lo = extreme16(); hi = extreme16();
    end else begin
      q  = int'($urandom_range(40)) - 20;
      lo = int'($urandom_range(40)) - 20;
      hi = int'($urandom_range(40)) - 20;
    end
    w.query  = clamp16(q);
    w.env_lo = clamp16(lo);
    w.env_hi = clamp16(hi);
    w.last   = last;
    return w;
  endfunction

  // offer one word after a random gap, wait for acceptance, then predict
  task automatic send_word(input step_word_t w, input bit use_typed, input bounds_t typed_val);
    int      gap;
    bit      done;
    bounds_t b;
    gap = idle_gap(tx_busy);
    if (gap > 0) begin
      @(negedge clk_i) s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w.env_hi, w.env_lo, w.query};
    s_axis_tlast  <= w.last;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    if (words_sent % 64 == 0) tx_busy = ($urandom_range(3) == 0);
    accumulate_step(w, done, b);
    if (done) begin
      series_sent++;
      if (use_typed) b = typed_val;
      pending_bounds = {pending_bounds, b};
    end
  endtask

  // stop offering, then wait for every expected result
  task automatic drain_results();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (pending_bounds.size() != 0) @(posedge clk_i);
  endtask

  function automatic dir_row_t dir_row(input int q, input int lo, input int hi,
                                       input bit last, input int unsigned reps,
                                       input bit typed, input int lb, input int ub);
    dir_row_t r;
    r.w.query  = clamp16(q);
    r.w.env_lo = clamp16(lo);
    r.w.env_hi = clamp16(hi);
    r.w.last   = last;
    r.reps     = reps;
    r.typed    = typed;
    r.want.lower = ROOT_W'(lb);
    r.want.upper = ROOT_W'(ub);
    return r;
  endfunction

  // ---------------------------------------------------------------- sequencer
  initial begin : main_seq
    dir_row_t directed_rows[$];
    int       random_items;
    int       len, len_pick;
    bit       paused;

    // fresh after reset: zero distance
    directed_rows = {directed_rows, dir_row(0, 0, 0, 1, 1, 1, 0, 0)};
    // full-scale distances both ways
    directed_rows = {directed_rows, dir_row(32767, -32768, -32768, 1, 1, 1, 65535, 65535)};
    directed_rows = {directed_rows, dir_row(-32768, 32767, 32767, 1, 1, 1, 65535, 65535)};
    // query on the low edge, then on the high edge: inside, no lower term
    directed_rows = {directed_rows, dir_row(5, 5, 10, 1, 1, 1, 0, 5)};
    directed_rows = {directed_rows, dir_row(10, 5, 10, 1, 1, 1, 0, 5)};
    // strictly inside
    directed_rows = {directed_rows, dir_row(0, -3, 4, 1, 1, 1, 0, 4)};
    // inverted envelope: q < low still counts as outside
    directed_rows = {directed_rows, dir_row(0, 100, -100, 1, 1, 1, 100, 100)};
    // multi-step series, predictor only
    directed_rows = {directed_rows, dir_row(-32768, -32768, 32767, 0, 1, 0, 0, 0)};
    directed_rows = {directed_rows, dir_row(32767, 0, 0, 0, 1, 0, 0, 0)};
    directed_rows = {directed_rows, dir_row(-1, 0, 1, 1, 1, 0, 0, 0)};
    // alternating bit patterns
    directed_rows = {directed_rows, dir_row(-21846, 21845, -1, 0, 1, 0, 0, 0)};
    directed_rows = {directed_rows, dir_row(21845, -21846, 0, 1, 1, 0, 0, 0)};
    // long series at full scale: root is exactly 16 * 65535
    directed_rows = {directed_rows,
                     dir_row(32767, -32768, -32768, 1, 256, 1, 1048560, 1048560)};
    // sums cleared after a long series
    directed_rows = {directed_rows, dir_row(3, 7, 9, 1, 1, 1, 4, 6)};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      for (int unsigned k = 0; k < directed_rows[i].reps; k++) begin
        step_word_t w;
        w      = directed_rows[i].w;
        w.last = directed_rows[i].w.last && (k == directed_rows[i].reps - 1);
        send_word(w, directed_rows[i].typed && w.last, directed_rows[i].want);
      end
    end
    // sender waits out every directed result before the random part
    drain_results();

    random_items = 0;
    paused       = 1'b0;
    while (random_items < RANDOM_ITEMS) begin
      len_pick = $urandom_range(99);
      if (len_pick < 70)      len = $urandom_range(1, 4);
      else if (len_pick < 97) len = $urandom_range(5, 32);
      else                    len = $urandom_range(100, 600);
      for (int k = 0; k < len; k++) send_word(random_step(k == len - 1), 1'b0, '0);
      random_items += len;
      if (!paused && random_items >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        drain_results();
      end
    end

    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d words in %0d series, %0d result words checked",
             words_sent, series_sent, results_seen);
    $display("%0d saturated series, %0d edge steps, %0d inverted-envelope steps",
             saturated_count, edge_steps, inverted_steps);
    if (fail_count == 0) begin
      $display("envelope_distance_bounds_unit regression: pass");
    end else begin
      $display("envelope_distance_bounds_unit regression: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver
  initial begin : result_sink
    int  gap;
    int  loops;
    bit  hold_done;
    hold_done = 1'b0;
    loops     = 0;
    wait (rst_ni);
    forever begin
      gap = idle_gap(rx_busy);
      // one long hold-off so the queue fills and input ready drops
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        gap       = LONG_HOLD;
      end
      if (gap > 0) begin
        @(negedge clk_i) m_axis_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i) m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      loops++;
      if (loops % 20 == 0) rx_busy = ($urandom_range(2) == 0);
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk_i) begin : result_check
    bounds_t want;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_bounds.size() == 0) begin
        $error("result word %h with no expectation waiting", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_bounds.pop_front();
        if (m_axis_tdata[21:0] !== want.lower) begin
          $error("lower_bound: expected %0d, got %0d", want.lower, m_axis_tdata[21:0]);
          fail_count++;
        end
        if (m_axis_tdata[43:22] !== want.upper) begin
          $error("upper_bound: expected %0d, got %0d", want.upper, m_axis_tdata[43:22]);
          fail_count++;
        end
        if (m_axis_tdata[47:44] !== 4'h0) begin
          $error("pad: expected 0, got %h", m_axis_tdata[47:44]);
          fail_count++;
        end
      end
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a handshake, %0d results outstanding",
               idle_cycles, pending_bounds.size());
      $display("envelope_distance_bounds_unit regression: fail");
      $finish;
    end
  end

endmodule

`default_nettype wire

>>> envelope_distance_bounds_unit.f
rtl/edb_pkg.sv
rtl/edb_front.sv
rtl/edb_queue.sv
rtl/edb_isqrt.sv
rtl/edb_back.sv
rtl/envelope_distance_bounds_unit.sv
sim/testbench.sv
